// File: rtl/cau_pkg.sv
// Shared types for the complex arithmetic unit.
// Holds the action codes and the control struct that rides along the divider cell chain.
// No dependencies.
package cau_pkg;

   // Operation codes carried in the low bits of the request transaction.
   typedef enum logic [2:0] {
      ACT_ADD   = 3'd0,
      ACT_SUB   = 3'd1,
      ACT_MUL   = 3'd2,
      ACT_DIV   = 3'd3,
      ACT_SCALE = 3'd4
   } act_type;

   // Control bits that travel with each transaction through the cell chain.
   typedef struct packed {
      logic valid;    // stage holds a transaction
      logic is_div;   // divide with a nonzero divisor: result comes from the quotient
      logic dz;       // divide with a zero-magnitude divisor
      logic neg_re;   // sign of the real dividend
      logic neg_im;   // sign of the imaginary dividend
   } ctl_type;

endpackage

// File: rtl/complex_arithmetic_unit.sv
// Complex arithmetic unit: add, subtract, multiply, divide and scale in signed fixed point.
// The pipeline is a multiplier stage, a combine stage, one divider cell per dividend bit and a
// saturating output register. Throughput is one transaction per cycle; the whole pipeline
// stalls only while a finished result waits on rsp_tready. Synchronous active-high reset
// empties every stage.
// Depends on cau_pkg and cau_div_cell.
module complex_arithmetic_unit #(
   parameter int DATA_WIDTH = 16,
   parameter int FRAC_BITS  = 8
) (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   // action, left_real, left_imag, right_real, right_imag, scale_factor; zero padded
   input  logic [((3+5*DATA_WIDTH+7)/8)*8-1:0] req_tdata,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   // result_real, result_imag, saturated, divide_by_zero; zero padded
   output logic [((2*DATA_WIDTH+2+7)/8)*8-1:0] rsp_tdata
);

   localparam int DW = DATA_WIDTH;
   localparam int PW = 2*DW;
   localparam int VW = 2*DW + 1;
   localparam int NW = 2*DW + FRAC_BITS;
   localparam int OW = ((2*DW+2+7)/8)*8;

   localparam logic signed [VW-1:0] VMAX = VW'((64'sd1 <<< (DW-1)) - 64'sd1);
   localparam logic signed [VW-1:0] VMIN = -VW'(64'sd1 <<< (DW-1));
   localparam logic [NW-1:0]        HALF = NW'(1) << (DW-1);

   logic advance;

   // Request field extraction.
   cau_pkg::act_type     act;
   logic signed [DW-1:0] lr, li, rr, ri, kf, rr_op, ri_op;

   assign act = cau_pkg::act_type'(req_tdata[2:0]);
   assign lr  = req_tdata[3+0*DW +: DW];
   assign li  = req_tdata[3+1*DW +: DW];
   assign rr  = req_tdata[3+2*DW +: DW];
   assign ri  = req_tdata[3+3*DW +: DW];
   assign kf  = req_tdata[3+4*DW +: DW];

   // Scale reuses the multiplier array with the scalar as a purely real right operand.
   assign rr_op = (act == cau_pkg::ACT_SCALE) ? kf : rr;
   assign ri_op = (act == cau_pkg::ACT_SCALE) ? '0 : ri;

   // Stage 1: all products and the full-precision sums.
   logic                 s1_valid_ff;
   cau_pkg::act_type     s1_act_ff;
   logic signed [PW-1:0] s1_rr_ff, s1_ii_ff, s1_ri_ff, s1_ir_ff, s1_dr_ff, s1_di_ff;
   logic signed [DW:0]   s1_re_ff, s1_im_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_act_ff <= act;
         s1_rr_ff  <= lr * rr_op;
         s1_ii_ff  <= li * ri_op;
         s1_ri_ff  <= lr * ri_op;
         s1_ir_ff  <= li * rr_op;
         s1_dr_ff  <= rr_op * rr_op;
         s1_di_ff  <= ri_op * ri_op;
         if (act == cau_pkg::ACT_SUB) begin
            s1_re_ff <= (DW+1)'(lr) - (DW+1)'(rr);
            s1_im_ff <= (DW+1)'(li) - (DW+1)'(ri);
         end else begin
            s1_re_ff <= (DW+1)'(lr) + (DW+1)'(rr);
            s1_im_ff <= (DW+1)'(li) + (DW+1)'(ri);
         end
      end
   end

   // Stage 2: combine products, form dividend magnitudes and the divisor.
   logic signed [VW-1:0] x_rr, x_ii, x_ri, x_ir, n_re, n_im, p_re, p_im;
   logic signed [VW-1:0] neg_re_v, neg_im_v;
   logic [PW-1:0]        den, mag_re, mag_im;
   cau_pkg::ctl_type     ctl0;
   logic signed [VW-1:0] val_re0, val_im0;

   always_comb begin
      x_rr     = VW'(s1_rr_ff);
      x_ii     = VW'(s1_ii_ff);
      x_ri     = VW'(s1_ri_ff);
      x_ir     = VW'(s1_ir_ff);
      n_re     = x_rr + x_ii;
      n_im     = x_ir - x_ri;
      p_re     = x_rr - x_ii;
      p_im     = x_ri + x_ir;
      neg_re_v = -n_re;
      neg_im_v = -n_im;
      mag_re   = n_re[VW-1] ? neg_re_v[PW-1:0] : n_re[PW-1:0];
      mag_im   = n_im[VW-1] ? neg_im_v[PW-1:0] : n_im[PW-1:0];
      den      = s1_dr_ff[PW-1:0] + s1_di_ff[PW-1:0];

      ctl0.valid  = s1_valid_ff;
      ctl0.is_div = (s1_act_ff == cau_pkg::ACT_DIV) && (den != '0);
      ctl0.dz     = (s1_act_ff == cau_pkg::ACT_DIV) && (den == '0);
      ctl0.neg_re = n_re[VW-1];
      ctl0.neg_im = n_im[VW-1];

      // Products drop the fraction bits with an arithmetic shift, i.e. floor.
      case (s1_act_ff)
         cau_pkg::ACT_ADD, cau_pkg::ACT_SUB: begin
            val_re0 = VW'(s1_re_ff);
            val_im0 = VW'(s1_im_ff);
         end
         cau_pkg::ACT_MUL: begin
            val_re0 = p_re >>> FRAC_BITS;
            val_im0 = p_im >>> FRAC_BITS;
         end
         cau_pkg::ACT_SCALE: begin
            val_re0 = x_rr >>> FRAC_BITS;
            val_im0 = x_ir >>> FRAC_BITS;
         end
         default: begin
            val_re0 = '0;
            val_im0 = '0;
         end
      endcase
   end

   // Divider cell chain, one quotient bit per cell.
   cau_pkg::ctl_type     ctl_c   [NW+1];
   logic [PW-1:0]        den_c   [NW+1];
   logic [PW:0]          rre_c   [NW+1];
   logic [PW:0]          rim_c   [NW+1];
   logic [NW-1:0]        wre_c   [NW+1];
   logic [NW-1:0]        wim_c   [NW+1];
   logic signed [VW-1:0] vre_c   [NW+1];
   logic signed [VW-1:0] vim_c   [NW+1];

   cau_pkg::ctl_type     s2_ctl_ff;
   logic [PW-1:0]        s2_den_ff;
   logic [NW-1:0]        s2_wre_ff, s2_wim_ff;
   logic signed [VW-1:0] s2_vre_ff, s2_vim_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_ctl_ff <= '0;
      end else if (advance) begin
         s2_ctl_ff <= ctl0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s2_den_ff <= den;
         s2_wre_ff <= NW'(mag_re) << FRAC_BITS;
         s2_wim_ff <= NW'(mag_im) << FRAC_BITS;
         s2_vre_ff <= val_re0;
         s2_vim_ff <= val_im0;
      end
   end

   assign ctl_c[0] = s2_ctl_ff;
   assign den_c[0] = s2_den_ff;
   assign rre_c[0] = '0;
   assign rim_c[0] = '0;
   assign wre_c[0] = s2_wre_ff;
   assign wim_c[0] = s2_wim_ff;
   assign vre_c[0] = s2_vre_ff;
   assign vim_c[0] = s2_vim_ff;

   for (genvar g = 0; g < NW; g++) begin : g_cell
      cau_div_cell #(.PW(PW), .NW(NW), .VW(VW)) u_cell (
         .clock       (clock),
         .reset       (reset),
         .advance     (advance),
         .ctl_in      (ctl_c[g]),
         .den_in      (den_c[g]),
         .rem_re_in   (rre_c[g]),
         .rem_im_in   (rim_c[g]),
         .work_re_in  (wre_c[g]),
         .work_im_in  (wim_c[g]),
         .val_re_in   (vre_c[g]),
         .val_im_in   (vim_c[g]),
         .ctl_out     (ctl_c[g+1]),
         .den_out     (den_c[g+1]),
         .rem_re_out  (rre_c[g+1]),
         .rem_im_out  (rim_c[g+1]),
         .work_re_out (wre_c[g+1]),
         .work_im_out (wim_c[g+1]),
         .val_re_out  (vre_c[g+1]),
         .val_im_out  (vim_c[g+1])
      );
   end

   // Saturate a signed value to the result range.
   function automatic logic [DW:0] clip_val(input logic signed [VW-1:0] v);
      logic [DW:0] r;
      if (v > VMAX) begin
         r = {1'b1, VMAX[DW-1:0]};
      end else if (v < VMIN) begin
         r = {1'b1, VMIN[DW-1:0]};
      end else begin
         r = {1'b0, v[DW-1:0]};
      end
      return r;
   endfunction

   // Saturate a signed quotient given as magnitude and sign.
   function automatic logic [DW:0] clip_quo(input logic [NW-1:0] q, input logic neg);
      logic [NW-1:0] nq;
      logic [DW:0]   r;
      nq = -q;
      if (neg) begin
         if (q > HALF) begin
            r = {1'b1, VMIN[DW-1:0]};
         end else begin
            r = {1'b0, nq[DW-1:0]};
         end
      end else if (q > HALF - NW'(1)) begin
         r = {1'b1, VMAX[DW-1:0]};
      end else begin
         r = {1'b0, q[DW-1:0]};
      end
      return r;
   endfunction

   // Output stage: pick the result source, saturate, and hold until taken.
   cau_pkg::ctl_type ctl_l;
   logic [DW:0]      sat_re, sat_im;
   logic             out_valid_ff;
   logic [DW-1:0]    out_re_ff, out_im_ff;
   logic             out_sat_ff, out_dz_ff;

   assign ctl_l = ctl_c[NW];

   always_comb begin
      if (ctl_l.is_div) begin
         sat_re = clip_quo(wre_c[NW], ctl_l.neg_re);
         sat_im = clip_quo(wim_c[NW], ctl_l.neg_im);
      end else if (ctl_l.dz) begin
         sat_re = '0;
         sat_im = '0;
      end else begin
         sat_re = clip_val(vre_c[NW]);
         sat_im = clip_val(vim_c[NW]);
      end
   end

   assign advance    = !out_valid_ff || rsp_tready;
   assign req_tready = advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= ctl_l.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_re_ff  <= sat_re[DW-1:0];
         out_im_ff  <= sat_im[DW-1:0];
         out_sat_ff <= sat_re[DW] | sat_im[DW];
         out_dz_ff  <= ctl_l.dz;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = OW'({out_dz_ff, out_sat_ff, out_im_ff, out_re_ff});

   // A zero divisor yields a zero, unsaturated result.
   a_dz_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && out_dz_ff |-> out_re_ff == '0 && out_im_ff == '0 && !out_sat_ff)
      else $error("divide by zero result not cleared");

   // An accepted transaction occupies the first stage on the next cycle.
   a_s1_fill: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> s1_valid_ff)
      else $error("accepted transaction lost at stage 1");

   // A result can only come from a transaction that left the cell chain.
   a_out_src: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(ctl_l.valid))
      else $error("result without a transaction");

endmodule

// File: rtl/cau_div_cell.sv
// One cell of the restoring divider chain: produces one quotient bit for each part.
// Depends on cau_pkg for the control struct.
// Non-divide results pass through the cell unchanged.
module cau_div_cell #(
   parameter int PW = 32,
   parameter int NW = 40,
   parameter int VW = 33
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 advance,
   input  cau_pkg::ctl_type     ctl_in,
   input  logic [PW-1:0]        den_in,
   input  logic [PW:0]          rem_re_in,
   input  logic [PW:0]          rem_im_in,
   input  logic [NW-1:0]        work_re_in,
   input  logic [NW-1:0]        work_im_in,
   input  logic signed [VW-1:0] val_re_in,
   input  logic signed [VW-1:0] val_im_in,
   output cau_pkg::ctl_type     ctl_out,
   output logic [PW-1:0]        den_out,
   output logic [PW:0]          rem_re_out,
   output logic [PW:0]          rem_im_out,
   output logic [NW-1:0]        work_re_out,
   output logic [NW-1:0]        work_im_out,
   output logic signed [VW-1:0] val_re_out,
   output logic signed [VW-1:0] val_im_out
);

   cau_pkg::ctl_type     ctl_ff;
   logic [PW-1:0]        den_ff;
   logic [PW:0]          rem_re_ff, rem_im_ff, rem_re_in_n, rem_im_in_n;
   logic [NW-1:0]        work_re_ff, work_im_ff, work_re_in_n, work_im_in_n;
   logic signed [VW-1:0] val_re_ff, val_im_ff;
   logic [PW:0]          trial_re, trial_im, den_ext;
   logic                 ge_re, ge_im;

   // Shift in the next dividend bit and subtract the divisor where it fits.
   always_comb begin
      den_ext      = {1'b0, den_in};
      trial_re     = {rem_re_in[PW-1:0], work_re_in[NW-1]};
      trial_im     = {rem_im_in[PW-1:0], work_im_in[NW-1]};
      ge_re        = trial_re >= den_ext;
      ge_im        = trial_im >= den_ext;
      rem_re_in_n  = ge_re ? trial_re - den_ext : trial_re;
      rem_im_in_n  = ge_im ? trial_im - den_ext : trial_im;
      work_re_in_n = {work_re_in[NW-2:0], ge_re};
      work_im_in_n = {work_im_in[NW-2:0], ge_im};
   end

   // Control state is reset; the data path only follows the control.
   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else if (advance) begin
         ctl_ff <= ctl_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         den_ff     <= den_in;
         rem_re_ff  <= rem_re_in_n;
         rem_im_ff  <= rem_im_in_n;
         work_re_ff <= work_re_in_n;
         work_im_ff <= work_im_in_n;
         val_re_ff  <= val_re_in;
         val_im_ff  <= val_im_in;
      end
   end

   assign ctl_out     = ctl_ff;
   assign den_out     = den_ff;
   assign rem_re_out  = rem_re_ff;
   assign rem_im_out  = rem_im_ff;
   assign work_re_out = work_re_ff;
   assign work_im_out = work_im_ff;
   assign val_re_out  = val_re_ff;
   assign val_im_out  = val_im_ff;

endmodule

// File: tb/sv/tb_complex_arithmetic_unit.sv
// Self-checking testbench for the complex arithmetic unit: drives random and corner-case
// operand transactions, predicts each result in fixed point, and compares every field.
// Depends on cau_pkg and complex_arithmetic_unit.
module tb_complex_arithmetic_unit;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int DW = 16;
   localparam int FB = 8;
   localparam int REQ_W = ((3 + 5 * DW + 7) / 8) * 8;
   localparam int RSP_W = ((2 * DW + 2 + 7) / 8) * 8;
   localparam int LATENCY = 2 * DW + FB + 3;
   localparam longint CYCLE_LIMIT = 400000;

   // Action codes the unit does not define; they must return an all-zero result.
   localparam logic [2:0] ACT_RSV0 = 3'd5;
   localparam logic [2:0] ACT_RSV1 = 3'd6;
   localparam logic [2:0] ACT_RSV2 = 3'd7;

   typedef struct packed {
      logic signed [DW-1:0] re;
      logic signed [DW-1:0] im;
      logic sat;
      logic dz;
   } cplx_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [REQ_W-1:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [RSP_W-1:0] rsp_tdata;

   cplx_result_type expected_results[$];
   int error_count = 0;
   longint cycle_count = 0;
   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int hold_off_cycles = 0;

   complex_arithmetic_unit #(.DATA_WIDTH(DW), .FRAC_BITS(FB)) u_top (.*);

   // Clock generation and run limit.
   initial begin
      forever begin
         #6 clock = ~clock;
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end
   end

   // Clips a wide value to the signed result range and notes any clipping.
   function automatic logic signed [DW-1:0] clip(input logic signed [79:0] v, inout logic sat);
      logic signed [79:0] hi;
      logic signed [79:0] lo;
      hi = (80'sd1 <<< (DW - 1)) - 1;
      lo = -(80'sd1 <<< (DW - 1));
      if (v > hi) begin
         sat = 1'b1;
         return hi[DW-1:0];
      end
      if (v < lo) begin
         sat = 1'b1;
         return lo[DW-1:0];
      end
      return v[DW-1:0];
   endfunction

   // Computes the expected result of one operation.
   function automatic cplx_result_type predict_complex(input logic [2:0] act,
         input logic signed [DW-1:0] lr, input logic signed [DW-1:0] li,
         input logic signed [DW-1:0] rr, input logic signed [DW-1:0] ri,
         input logic signed [DW-1:0] k);
      logic signed [79:0] re;
      logic signed [79:0] im;
      logic signed [79:0] den;
      cplx_result_type r;
      re = 0;
      im = 0;
      r = '0;
      case (act)
         cau_pkg::ACT_ADD: begin
            re = 80'(lr) + 80'(rr);
            im = 80'(li) + 80'(ri);
         end
         cau_pkg::ACT_SUB: begin
            re = 80'(lr) - 80'(rr);
            im = 80'(li) - 80'(ri);
         end
         cau_pkg::ACT_MUL: begin
            re = (80'(lr) * 80'(rr) - 80'(li) * 80'(ri)) >>> FB;
            im = (80'(lr) * 80'(ri) + 80'(li) * 80'(rr)) >>> FB;
         end
         cau_pkg::ACT_DIV: begin
            den = 80'(rr) * 80'(rr) + 80'(ri) * 80'(ri);
            if (den == 0) begin
               r.dz = 1'b1;
            end else begin
               // Signed division truncates toward zero.
               re = ((80'(lr) * 80'(rr) + 80'(li) * 80'(ri)) <<< FB) / den;
               im = ((80'(li) * 80'(rr) - 80'(lr) * 80'(ri)) <<< FB) / den;
            end
         end
         cau_pkg::ACT_SCALE: begin
            re = (80'(lr) * 80'(k)) >>> FB;
            im = (80'(li) * 80'(k)) >>> FB;
         end
         default: ;
      endcase
      r.re = clip(re, r.sat);
      r.im = clip(im, r.sat);
      return r;
   endfunction

   // Sends one transaction and records its expected result.
   // The request stays valid afterwards until the next idle cycle or drain.
   task automatic send_operation(input logic [2:0] act, input logic [DW-1:0] lr,
         input logic [DW-1:0] li, input logic [DW-1:0] rr, input logic [DW-1:0] ri,
         input logic [DW-1:0] k);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= REQ_W'({k, ri, rr, li, lr, act});
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      expected_results.push_back(predict_complex(act, lr, li, rr, ri, k));
      @(negedge clock);
   endtask

   function automatic logic [DW-1:0] pick_operand();
      case ($urandom_range(7))
         0: return 16'h8000;
         1: return 16'h7fff;
         2: return 16'h0000;
         3: return 16'(signed'($urandom_range(512)) - 256);
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic send_random(input int count);
      logic [2:0] act;
      repeat (count) begin
         act = ($urandom_range(19) == 0) ? 3'($urandom_range(ACT_RSV2, ACT_RSV0)) :
               3'($urandom_range(cau_pkg::ACT_SCALE));
         if (act == cau_pkg::ACT_DIV && $urandom_range(9) == 0)
            send_operation(act, pick_operand(), pick_operand(), '0, '0, pick_operand());
         else
            send_operation(act, pick_operand(), pick_operand(), pick_operand(),
               pick_operand(), pick_operand());
      end
   endtask

   // Stops offering requests and waits until every expected result has come back.
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (expected_results.size() != 0) @(negedge clock);
   endtask

   // Response side: random stalls, an optional long hold-off, and checking.
   always @(negedge clock) begin
      if (hold_off_cycles > 0) begin
         rsp_tready <= 1'b0;
         hold_off_cycles <= hold_off_cycles - 1;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   always @(posedge clock) begin
      cplx_result_type got;
      cplx_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.re = rsp_tdata[DW-1:0];
         got.im = rsp_tdata[2*DW-1:DW];
         got.sat = rsp_tdata[2*DW];
         got.dz = rsp_tdata[2*DW+1];
         if (expected_results.size() == 0) begin
            $error("unexpected result transaction %h", rsp_tdata);
            error_count++;
         end else begin
            want = expected_results.pop_front();
            if (got.re !== want.re) begin
               $error("result_real expected %0d actual %0d", want.re, got.re);
               error_count++;
            end
            if (got.im !== want.im) begin
               $error("result_imag expected %0d actual %0d", want.im, got.im);
               error_count++;
            end
            if (got.sat !== want.sat) begin
               $error("saturated expected %0b actual %0b", want.sat, got.sat);
               error_count++;
            end
            if (got.dz !== want.dz) begin
               $error("divide_by_zero expected %0b actual %0b", want.dz, got.dz);
               error_count++;
            end
         end
      end
   end

   // Corner cases: extremes, every action, zero divisor and unused codes.
   task automatic test_directed();
      send_operation(cau_pkg::ACT_ADD, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 16'h0000);
      send_operation(cau_pkg::ACT_ADD, 16'h0100, 16'hff00, 16'h0080, 16'h0040, 16'hffff);
      send_operation(cau_pkg::ACT_SUB, 16'h8000, 16'h7fff, 16'h7fff, 16'h8000, 16'h1234);
      send_operation(cau_pkg::ACT_SUB, 16'h0000, 16'h0000, 16'h8000, 16'h0001, 16'h0000);
      send_operation(cau_pkg::ACT_MUL, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h0000);
      send_operation(cau_pkg::ACT_MUL, 16'h0100, 16'h0100, 16'h0100, 16'hff00, 16'h0000);
      send_operation(cau_pkg::ACT_MUL, 16'hffff, 16'h0001, 16'h0001, 16'hffff, 16'h0000);
      send_operation(cau_pkg::ACT_DIV, 16'h0100, 16'h0200, 16'h0000, 16'h0000, 16'h7fff);
      send_operation(cau_pkg::ACT_DIV, 16'h7fff, 16'h8000, 16'h0001, 16'h0000, 16'h0000);
      send_operation(cau_pkg::ACT_DIV, 16'h0300, 16'hfd00, 16'h0100, 16'h0100, 16'h0000);
      send_operation(cau_pkg::ACT_DIV, 16'hffff, 16'h0001, 16'h7fff, 16'h8000, 16'h0000);
      send_operation(cau_pkg::ACT_SCALE, 16'h8000, 16'h7fff, 16'h1111, 16'h2222, 16'h8000);
      send_operation(cau_pkg::ACT_SCALE, 16'hffff, 16'h0001, 16'h0000, 16'h0000, 16'h0080);
      send_operation(cau_pkg::ACT_SCALE, 16'h0100, 16'hff00, 16'h0000, 16'h0000, 16'h7fff);
      send_operation(ACT_RSV0, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
      send_operation(ACT_RSV1, 16'h8000, 16'h8000, 16'h0000, 16'h0000, 16'h0000);
      send_operation(ACT_RSV2, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff);
      wait_drained();
   endtask

   task automatic test_random_phases();
      send_idle_pct = 0;  recv_stall_pct = 0;  send_random(400);
      send_idle_pct = 61; recv_stall_pct = 0;  send_random(350);
      send_idle_pct = 0;  recv_stall_pct = 61; send_random(350);
      send_idle_pct = 28; recv_stall_pct = 28; send_random(350);
      // Sender pauses here until every outstanding result has come back.
      wait_drained();
   endtask

   // Receiver holds off long enough for the pipeline to fill and stall its input.
   task automatic test_backpressure();
      send_idle_pct = 0;
      recv_stall_pct = 10;
      @(negedge clock);
      hold_off_cycles <= 4 * LATENCY;
      send_random(150);
      wait_drained();
   endtask

   initial begin
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed();
      test_random_phases();
      test_backpressure();
      repeat (LATENCY + 10) @(negedge clock);
      if (error_count == 0 && expected_results.size() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
